[hw/rtl/tvbb_pkg.sv]
// Shared types and constants for the transformed vertex bounding box core.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package tvbb_pkg;

    // Coefficient table layout.
    localparam int NUM_COEF     = 15;
    localparam int COEF_IDX_W   = 4;
    localparam int NUM_AXES     = 3;
    localparam int ROT_BASE     = 0;
    localparam int OFF_A_BASE   = 9;
    localparam int OFF_B_BASE   = 12;

    // Item kinds carried in tuser.
    localparam logic FUNC_COEF   = 1'b0;
    localparam logic FUNC_VERTEX = 1'b1;

    // Control that travels alongside the data of one pipeline stage.
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

endpackage

[hw/rtl/tvbb_xform.sv]
// First stage: coefficient table and the nine coordinate-by-coefficient products.
// Depends on tvbb_pkg.
`timescale 1ns / 1ps

module tvbb_xform #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  coef_we,
    input  logic [tvbb_pkg::COEF_IDX_W-1:0]       coef_idx,
    input  logic signed [COORD_WIDTH-1:0]         coef_val,
    input  logic                                  advance,
    input  tvbb_pkg::stage_ctl_t                  in_ctl,
    input  logic signed [COORD_WIDTH-1:0]         vtx [0:tvbb_pkg::NUM_AXES-1],
    input  logic                                  include_offset,
    output tvbb_pkg::stage_ctl_t                  out_ctl,
    output logic signed [2*COORD_WIDTH-1:0]       prod [0:3*tvbb_pkg::NUM_AXES-1],
    output logic signed [COORD_WIDTH:0]           offset [0:tvbb_pkg::NUM_AXES-1]
);

    localparam int PW = 2 * COORD_WIDTH;

    logic signed [COORD_WIDTH-1:0] coef_reg [0:tvbb_pkg::NUM_COEF-1];
    logic signed [PW-1:0]          prod_reg [0:3*tvbb_pkg::NUM_AXES-1];
    logic signed [PW-1:0]          prod_next [0:3*tvbb_pkg::NUM_AXES-1];
    logic signed [COORD_WIDTH:0]   off_reg [0:tvbb_pkg::NUM_AXES-1];
    logic signed [COORD_WIDTH:0]   off_next [0:tvbb_pkg::NUM_AXES-1];
    tvbb_pkg::stage_ctl_t          ctl_reg;

    // Each table word sits in its own register; index 15 matches none of them.
    for (genvar k = 0; k < tvbb_pkg::NUM_COEF; k++) begin : g_coef
        always_ff @(posedge aclk) begin
            if (coef_we && (coef_idx == tvbb_pkg::COEF_IDX_W'(k))) begin
                coef_reg[k] <= coef_val;
            end
        end
    end

    // Axis a uses coordinate t with word 3*t + a of the rotation.
    for (genvar a = 0; a < tvbb_pkg::NUM_AXES; a++) begin : g_axis
        for (genvar t = 0; t < tvbb_pkg::NUM_AXES; t++) begin : g_term
            assign prod_next[3*a + t] = PW'(vtx[t]) * PW'(coef_reg[tvbb_pkg::ROT_BASE + 3*t + a]);
        end
        assign off_next[a] = include_offset
            ? ((COORD_WIDTH+1)'(coef_reg[tvbb_pkg::OFF_A_BASE + a])
               + (COORD_WIDTH+1)'(coef_reg[tvbb_pkg::OFF_B_BASE + a]))
            : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (advance) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_ctl.valid) begin
            prod_reg <= prod_next;
            off_reg  <= off_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign prod    = prod_reg;
    assign offset  = off_reg;

endmodule

[hw/rtl/tvbb_sum.sv]
// Second stage: scales and saturates the products, then forms each saturated axis sum.
// Depends on tvbb_pkg.
`timescale 1ns / 1ps

module tvbb_sum #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  tvbb_pkg::stage_ctl_t            in_ctl,
    input  logic signed [2*COORD_WIDTH-1:0] prod [0:3*tvbb_pkg::NUM_AXES-1],
    input  logic signed [COORD_WIDTH:0]     offset [0:tvbb_pkg::NUM_AXES-1],
    output tvbb_pkg::stage_ctl_t            out_ctl,
    output logic signed [COORD_WIDTH-1:0]   coord [0:tvbb_pkg::NUM_AXES-1]
);

    localparam int W     = COORD_WIDTH;
    localparam int PW    = 2 * COORD_WIDTH;
    localparam int SUM_W = COORD_WIDTH + 3;
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0]   coord_reg [0:tvbb_pkg::NUM_AXES-1];
    logic signed [W-1:0]   coord_next [0:tvbb_pkg::NUM_AXES-1];
    logic signed [W-1:0]   term [0:3*tvbb_pkg::NUM_AXES-1];
    tvbb_pkg::stage_ctl_t  ctl_reg;

    // Product scaling: arithmetic shift drops the fraction (floor), then clamp.
    always_comb begin
        logic signed [PW-1:0] q;
        for (int k = 0; k < 3*tvbb_pkg::NUM_AXES; k++) begin
            q = prod[k] >>> FRAC_BITS;
            if ((&q[PW-1:W-1]) || !(|q[PW-1:W-1])) begin
                term[k] = q[W-1:0];
            end else begin
                term[k] = q[PW-1] ? MINV : MAXV;
            end
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] s;
        for (int a = 0; a < tvbb_pkg::NUM_AXES; a++) begin
            s = SUM_W'(term[3*a]) + SUM_W'(term[3*a + 1]) + SUM_W'(term[3*a + 2])
              + SUM_W'(offset[a]);
            if ((&s[SUM_W-1:W-1]) || !(|s[SUM_W-1:W-1])) begin
                coord_next[a] = s[W-1:0];
            end else begin
                coord_next[a] = s[SUM_W-1] ? MINV : MAXV;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (advance) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_ctl.valid) begin
            coord_reg <= coord_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign coord   = coord_reg;

endmodule

[hw/rtl/tvbb_bound.sv]
// Third stage: running per-axis extremes and the registered box result.
// Depends on tvbb_pkg.
`timescale 1ns / 1ps

module tvbb_bound #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tvbb_pkg::stage_ctl_t          in_ctl,
    input  logic signed [COORD_WIDTH-1:0] coord [0:tvbb_pkg::NUM_AXES-1],
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [9*COORD_WIDTH-1:0]      out_data
);

    localparam int W = COORD_WIDTH;
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] min_reg [0:tvbb_pkg::NUM_AXES-1];
    logic signed [W-1:0] max_reg [0:tvbb_pkg::NUM_AXES-1];
    logic signed [W-1:0] min_new [0:tvbb_pkg::NUM_AXES-1];
    logic signed [W-1:0] max_new [0:tvbb_pkg::NUM_AXES-1];
    logic signed [W-1:0] ctr_new [0:tvbb_pkg::NUM_AXES-1];
    logic [9*W-1:0]      data_reg;
    logic [9*W-1:0]      data_next;
    logic                valid_reg;
    logic                fire;

    // Only a closing vertex needs room in the result register.
    assign in_ready = !in_ctl.last || !valid_reg || out_ready;
    assign fire     = in_ctl.valid && in_ready;

    always_comb begin
        logic signed [W:0] mid;
        for (int a = 0; a < tvbb_pkg::NUM_AXES; a++) begin
            min_new[a] = (coord[a] < min_reg[a]) ? coord[a] : min_reg[a];
            max_new[a] = (coord[a] > max_reg[a]) ? coord[a] : max_reg[a];
            mid        = (W+1)'(max_new[a]) + (W+1)'(min_new[a]);
            ctr_new[a] = mid[W:1];
            data_next[a*W +: W]       = min_new[a];
            data_next[(3 + a)*W +: W] = max_new[a];
            data_next[(6 + a)*W +: W] = ctr_new[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < tvbb_pkg::NUM_AXES; a++) begin
                min_reg[a] <= MAXV;
                max_reg[a] <= MINV;
            end
            valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                for (int a = 0; a < tvbb_pkg::NUM_AXES; a++) begin
                    min_reg[a] <= in_ctl.last ? MAXV : min_new[a];
                    max_reg[a] <= in_ctl.last ? MINV : max_new[a];
                end
            end
            if (fire && in_ctl.last) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_ctl.last) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/transformed_vertex_bounding_box_core.sv]
// Top level of the transformed vertex bounding box core: ports and stage wiring.
// Depends on tvbb_pkg, tvbb_xform, tvbb_sum and tvbb_bound.
`timescale 1ns / 1ps

// Channel   | Direction | Transaction
// ----------+-----------+----------------------------------------------------
// s_*       | in        | coefficient word write (tuser 0) or vertex (tuser 1)
// m_*       | out       | box min, max and center, one per closing vertex
// cfg_*     | in        | include_offset register write
//
// One transaction is accepted every clock cycle when no stall is pending.
// A vertex passes three register stages (multiply, scale and sum, extreme
// update), and its box result is registered in the last of them.
// A coefficient write takes effect in the table on the cycle after it is
// accepted and is seen by every vertex accepted after it.
// Reset is synchronous and active low; it clears the stage valid bits, the
// extremes to their sentinels and include_offset to 1. The table is not reset.
// Only a closing vertex waits on m_tready, so a held result stalls the input
// only once such a vertex reaches the last stage.

module transformed_vertex_bounding_box_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Lowest bit up: coef_index, coef_value, vertex_x, vertex_y, vertex_z, zero fill.
    input  logic [((tvbb_pkg::COEF_IDX_W + 4*COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // Bit 0: func.
    input  logic [0:0]             s_tuser,
    input  logic                   s_tlast,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Lowest bit up: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
    // box_max_z, center_x, center_y, center_z, zero fill.
    output logic [((9*COORD_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);

    localparam int W          = COORD_WIDTH;
    localparam int OUT_BITS   = 9 * COORD_WIDTH;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CI         = tvbb_pkg::COEF_IDX_W;

    logic                  include_offset_reg;
    logic                  coef_we;
    logic                  s1_adv;
    logic                  s2_adv;
    logic                  s3_ready;
    logic signed [W-1:0]   vtx [0:tvbb_pkg::NUM_AXES-1];
    logic signed [2*W-1:0] prod [0:3*tvbb_pkg::NUM_AXES-1];
    logic signed [W:0]     offset [0:tvbb_pkg::NUM_AXES-1];
    logic signed [W-1:0]   coord [0:tvbb_pkg::NUM_AXES-1];
    logic [OUT_BITS-1:0]   box_data;
    tvbb_pkg::stage_ctl_t  in_ctl;
    tvbb_pkg::stage_ctl_t  s1_ctl;
    tvbb_pkg::stage_ctl_t  s2_ctl;

    // The configuration register is always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            include_offset_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            include_offset_reg <= cfg_data;
        end
    end

    // A stage loads whenever it is empty or its contents move on.
    assign s2_adv   = !s2_ctl.valid || s3_ready;
    assign s1_adv   = !s1_ctl.valid || s2_adv;
    assign s_tready = s1_adv;

    // Coefficient writes update the table directly and send an empty slot down the pipeline.
    assign coef_we      = s_tvalid && s_tready && (s_tuser[0] == tvbb_pkg::FUNC_COEF);
    assign in_ctl.valid = s_tvalid && (s_tuser[0] == tvbb_pkg::FUNC_VERTEX);
    assign in_ctl.last  = s_tlast;

    for (genvar a = 0; a < tvbb_pkg::NUM_AXES; a++) begin : g_vtx
        assign vtx[a] = s_tdata[CI + (a + 1)*W +: W];
    end

    tvbb_xform #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_xform (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .coef_we        (coef_we),
        .coef_idx       (s_tdata[CI-1:0]),
        .coef_val       (s_tdata[CI +: W]),
        .advance        (s1_adv),
        .in_ctl         (in_ctl),
        .vtx            (vtx),
        .include_offset (include_offset_reg),
        .out_ctl        (s1_ctl),
        .prod           (prod),
        .offset         (offset)
    );

    tvbb_sum #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_sum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (s2_adv),
        .in_ctl  (s1_ctl),
        .prod    (prod),
        .offset  (offset),
        .out_ctl (s2_ctl),
        .coord   (coord)
    );

    tvbb_bound #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_bound (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (s2_ctl),
        .coord     (coord),
        .in_ready  (s3_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (box_data)
    );

    assign m_tdata = OUT_DATA_W'(box_data);

endmodule
